@@ rtl/cfar_pkg.sv @@
// cfar_pkg: shared widths, constants and the pipeline item type for the
// one-sided CA-CFAR detector. No dependencies.
package cfar_pkg;

    localparam int C_REF_CELLS   = 50;   // default reference window length
    localparam int C_GUARD_CELLS = 10;   // default guard cells

    localparam int SAMPLE_W    = 16;
    localparam int ALPHA_W     = 16;
    localparam int THR_W       = 24;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd2470;   // ~9.65 in Q8.8

    // One item moving down the pipeline.
    typedef struct packed {
        logic                       vld;     // stage holds an item
        logic                       vres;    // window was full for this item
        logic signed [SAMPLE_W-1:0] sample;  // cell under test
    } t_item;

endpackage

@@ rtl/cfar_ram.sv @@
// cfar_ram: generic single-write, single-read synchronous RAM with a
// registered read port (old data on a same-address collision). No dependencies.
module cfar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cfar_window.sv @@
// cfar_window: sample ring in two RAM copies, write slot / fill counters and
// the running reference sum. Depends on cfar_pkg and cfar_ram.
module cfar_window #(
    parameter int REF_CELLS   = 50,
    parameter int GUARD_CELLS = 10,
    parameter int SUM_W       = $clog2(REF_CELLS) + 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [cfar_pkg::SAMPLE_W-1:0]  i_sample,
    output cfar_pkg::t_item                       o_item,
    output logic signed [SUM_W-1:0]               o_sum
);
    import cfar_pkg::*;

    localparam int W_LEN  = REF_CELLS + GUARD_CELLS + 1;
    localparam int ADDR_W = $clog2(W_LEN);
    localparam int CNT_W  = $clog2(W_LEN + 1);

    logic                       w_accept;
    logic [ADDR_W-1:0]          r_slot, n_slot;
    logic [ADDR_W:0]            w_enter_sum;
    logic [ADDR_W-1:0]          w_enter;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [SAMPLE_W-1:0]        w_old, w_enter_data;

    logic                       r_s1_vld, r_s1_full, r_s1_add, r_s1_vres;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    t_item                      r_s2;

    assign w_accept = i_valid & i_en;

    // oldest guard cell: slot + REF_CELLS modulo window length
    always_comb begin
        w_enter_sum = {1'b0, r_slot} + (ADDR_W+1)'(REF_CELLS);
        if (w_enter_sum >= (ADDR_W+1)'(W_LEN)) begin
            w_enter_sum = w_enter_sum - (ADDR_W+1)'(W_LEN);
        end
        w_enter = w_enter_sum[ADDR_W-1:0];
    end

    always_comb begin
        n_slot = (r_slot == ADDR_W'(W_LEN - 1)) ? '0 : r_slot + 1'b1;
        n_fill = (r_fill == CNT_W'(W_LEN)) ? r_fill : r_fill + 1'b1;
    end

    // two copies: one read port each for the leaving and the entering cell
    cfar_ram #(.WIDTH(SAMPLE_W), .DEPTH(W_LEN)) u_ram_old (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_slot),
        .i_wdata (i_sample),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_old)
    );

    cfar_ram #(.WIDTH(SAMPLE_W), .DEPTH(W_LEN)) u_ram_ref (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_slot),
        .i_wdata (i_sample),
        .i_re    (w_accept),
        .i_raddr (w_enter),
        .o_rdata (w_enter_data)
    );

    always_comb begin
        n_sum = r_sum;
        if (r_s1_full) begin
            n_sum = r_sum - SUM_W'($signed(w_old)) + SUM_W'($signed(w_enter_data));
        end else if (r_s1_add) begin
            n_sum = r_sum + SUM_W'(r_s1_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_fill    <= '0;
            r_s1_vld  <= 1'b0;
            r_s1_full <= 1'b0;
            r_s1_add  <= 1'b0;
            r_s1_vres <= 1'b0;
            r_sum     <= '0;
            r_s2      <= '0;
        end else if (i_en) begin
            r_s1_vld <= w_accept;
            if (w_accept) begin
                r_slot    <= n_slot;
                r_fill    <= n_fill;
                r_s1_full <= (r_fill == CNT_W'(W_LEN));
                r_s1_add  <= (r_fill < CNT_W'(REF_CELLS));
                r_s1_vres <= (r_fill >= CNT_W'(W_LEN - 1));
            end
            if (r_s1_vld) begin
                r_sum <= n_sum;
            end
            r_s2.vld    <= r_s1_vld;
            r_s2.vres   <= r_s1_vres;
            r_s2.sample <= r_s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= i_sample;
        end
    end

    assign o_item = r_s2;
    assign o_sum  = r_sum;

endmodule

@@ rtl/cfar_scale.sv @@
// cfar_scale: threshold = floor(sum * alpha / (REF_CELLS * 256)), pipelined
// as product, offset, reciprocal multiply and one-step correction. Depends on cfar_pkg.
module cfar_scale #(
    parameter int REF_CELLS = 50,
    parameter int SUM_W     = $clog2(REF_CELLS) + 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  cfar_pkg::t_item                       i_item,
    input  logic signed [SUM_W-1:0]               i_sum,
    input  logic [cfar_pkg::ALPHA_W-1:0]          i_alpha,
    output cfar_pkg::t_item                       o_item,
    output logic signed [cfar_pkg::THR_W-1:0]     o_thr
);
    import cfar_pkg::*;

    localparam int PROD_W = SUM_W + ALPHA_W + 1;
    localparam int P8_W   = PROD_W - 8;
    localparam int X_W    = SUM_W + 8;      // offset dividend, always non-negative
    localparam int M_W    = X_W + 1;
    localparam logic [63:0] OFS64   = 64'(REF_CELLS) << (THR_W - 1);
    localparam logic [63:0] RECIP64 = (64'd1 << X_W) / REF_CELLS;

    t_item                    r_it1, r_it2, r_it3, r_it4;
    logic signed [PROD_W-1:0] w_prod, r_prod;
    logic [P8_W-1:0]          w_xsum;
    logic [X_W-1:0]           r_x, r_x3;
    logic [X_W+M_W-1:0]       w_qprod;
    logic [THR_W-1:0]         r_qe, r_q, w_q;
    logic [X_W-1:0]           w_qr, w_rem;

    // floor(prod/256) is the arithmetic shift; adding REF_CELLS*2^23 makes
    // it non-negative so the quotient comes out offset by 2^23
    assign w_prod  = i_sum * $signed({1'b0, i_alpha});
    assign w_xsum  = r_prod[PROD_W-1:8] + OFS64[P8_W-1:0];
    assign w_qprod = r_x * RECIP64[M_W-1:0];

    // reciprocal estimate is low by at most one
    always_comb begin
        w_qr  = X_W'(r_qe) * X_W'(REF_CELLS);
        w_rem = r_x3 - w_qr;
        w_q   = (w_rem >= X_W'(REF_CELLS)) ? r_qe + THR_W'(1) : r_qe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it1 <= '0;
            r_it2 <= '0;
            r_it3 <= '0;
            r_it4 <= '0;
        end else if (i_en) begin
            r_it1 <= i_item;
            r_it2 <= r_it1;
            r_it3 <= r_it2;
            r_it4 <= r_it3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod;
            r_x    <= w_xsum[X_W-1:0];
            r_qe   <= w_qprod[X_W+THR_W-1:X_W];
            r_x3   <= r_x;
            r_q    <= w_q;
        end
    end

    assign o_item = r_it4;
    assign o_thr  = {~r_q[THR_W-1], r_q[THR_W-2:0]};

endmodule

@@ rtl/cfar_out.sv @@
// cfar_out: detect compare, result formatting and the output register with
// a skid slot. Depends on cfar_pkg.
module cfar_out (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cfar_pkg::t_item                       i_item,
    input  logic signed [cfar_pkg::THR_W-1:0]     i_thr,
    input  logic                                  i_tready,
    output logic                                  o_tvalid,
    output logic [cfar_pkg::OUT_TDATA_W-1:0]      o_tdata,
    output logic                                  o_tuser,
    output logic                                  o_ready
);
    import cfar_pkg::*;

    logic signed [THR_W-1:0]  w_sample_x;
    logic                     w_det;
    logic [THR_W-1:0]         w_thr;
    logic [OUT_TDATA_W:0]     w_res, r_out, r_skid;   // {tuser, tdata}
    logic                     r_out_vld, r_skid_vld;

    // sample > floor(mean*alpha) is the same test as the exact cross-product
    always_comb begin
        w_sample_x = THR_W'(i_item.sample);
        w_det      = i_item.vres && (w_sample_x > i_thr);
        w_thr      = i_item.vres ? i_thr : '0;
        w_res      = {i_item.vres, {(OUT_TDATA_W-THR_W-1){1'b0}}, w_det, w_thr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_item.vld) begin
            if (r_out_vld && !i_tready) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (i_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_tready) begin
                r_out <= r_skid;
            end
        end else if (i_item.vld) begin
            if (r_out_vld && !i_tready) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out[OUT_TDATA_W-1:0];
    assign o_tuser  = r_out[OUT_TDATA_W];
    assign o_ready  = !r_skid_vld;

endmodule

@@ rtl/cfar_threshold_detector.sv @@
// cfar_threshold_detector: top level of the one-sided cell-averaging CFAR.
// Depends on cfar_pkg, cfar_window, cfar_scale, cfar_out (and cfar_ram below).
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[15:0] sample
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[23:0] threshold, [24] detect;
//                                               tuser valid_res
//  cfg       in   i_cfg_we                      i_cfg_wdata alpha_q8 (Q8.8)
//
// One request per clock while no stall holds the pipeline; the ring is two RAM
// copies written and read at the accept edge, and the sum is updated from their reads.
// A result reaches m_axis through the sum, product, offset, reciprocal multiply,
// correction and output registers after its request is accepted (the RAM
// read shares the accept edge).
// Reset: synchronous, active low; clears counters, sum, pipeline and alpha (2470).
// The ring itself is not cleared; entries are only used once written.
// Stalls: a skid slot behind the output register; s_axis_tready drops only
// when both hold a result, and then the whole pipeline freezes.
module cfar_threshold_detector #(
    parameter int REF_CELLS   = cfar_pkg::C_REF_CELLS,    // 1..256
    parameter int GUARD_CELLS = cfar_pkg::C_GUARD_CELLS   // 0..64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side, tdata: [15:0] sample
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cfar_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // master side, tdata: [23:0] threshold, [24] detect, [31:25] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cfar_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: [0] valid_res
    output logic                                m_axis_tuser,
    // alpha_q8 write
    input  logic                                i_cfg_we,
    input  logic [cfar_pkg::ALPHA_W-1:0]        i_cfg_wdata
);
    import cfar_pkg::*;

    // |sum| <= REF_CELLS * 2^15
    localparam int SUM_W = $clog2(REF_CELLS) + 16;

    logic [ALPHA_W-1:0]      r_alpha;
    logic                    w_ready;
    t_item                   w_win_item, w_scl_item;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [THR_W-1:0] w_thr;

    // alpha is to be written only while the pipeline is empty; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            r_alpha <= i_cfg_wdata;
        end
    end

    cfar_window #(
        .REF_CELLS   (REF_CELLS),
        .GUARD_CELLS (GUARD_CELLS),
        .SUM_W       (SUM_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_ready),
        .i_valid  (s_axis_tvalid),
        .i_sample ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .o_item   (w_win_item),
        .o_sum    (w_sum)
    );

    cfar_scale #(
        .REF_CELLS (REF_CELLS),
        .SUM_W     (SUM_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ready),
        .i_item  (w_win_item),
        .i_sum   (w_sum),
        .i_alpha (r_alpha),
        .o_item  (w_scl_item),
        .o_thr   (w_thr)
    );

    cfar_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_scl_item),
        .i_thr    (w_thr),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_ready  (w_ready)
    );

    assign s_axis_tready = w_ready;

endmodule

@@ rtl/cfar_checker.sv @@
// cfar_checker: port-level assertions for cfar_threshold_detector, attached
// by the bind below. Depends on nothing but the top level's ports.
module cfar_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser
);

    logic r_seen_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_full <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser) begin
            r_seen_full <= 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stalled after reset");

    a_not_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("result before window full is not zero");

    a_detect_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tuser)
        else $error("detect set while window not full");

    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_seen_full |-> m_axis_tuser)
        else $error("valid_res fell after window was full");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind cfar_threshold_detector cfar_checker u_cfar_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ sim/cfar_threshold_detector_test.sv @@
`timescale 1ns / 1ps
// cfar_threshold_detector_test: self-checking bench for the one-sided CA-CFAR detector.
// Depends on cfar_pkg and the cfar_threshold_detector RTL; results are predicted in-bench.
module cfar_threshold_detector_test;
    import cfar_pkg::*;

    localparam int     WIN_LEN      = C_REF_CELLS + C_GUARD_CELLS + 1;
    localparam longint MEAN_DEN     = longint'(C_REF_CELLS) * 256;   // N * 2^8 (Q8.8 alpha)
    localparam int     PIPE_LATENCY = 6;      // accept-to-output
    localparam int     STALL_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int     PHASES       = 7;
    localparam int     PHASE_ITEMS  = 45;

    // one expected output beat
    typedef struct packed {
        logic signed [THR_W-1:0] threshold;
        logic                    detect;
        logic                    valid_res;
    } t_detection;

    // shapes of random sample runs
    typedef enum int {
        SEG_NOISE,     // full-scale white samples
        SEG_CLUTTER,   // low-level clutter on an offset, sparse strong targets
        SEG_FLAT       // constant run long enough to fill the window, then a step
    } t_segment;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;    // [15:0] sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [23:0] threshold, [24] detect, [31:25] zero
    logic                   m_axis_tuser;          // [0] valid_res
    logic                   i_cfg_we      = 1'b0;
    logic [ALPHA_W-1:0]     i_cfg_wdata   = '0;

    // bench-side copy of the detector state
    logic signed [SAMPLE_W-1:0] cell_ring [WIN_LEN];
    int                         ring_slot  = 0;
    int                         cells_held = 0;
    longint                     ref_sum    = 0;
    logic [ALPHA_W-1:0]         alpha_q8   = ALPHA_RESET;

    logic [IN_TDATA_W-1:0] pending_samples [$];
    t_detection            expected_detections [$];
    int                    mismatch_count = 0;
    int                    stall_cycles   = 0;
    int                    send_idle_pct  = 0;
    int                    recv_idle_pct  = 0;

    cfar_threshold_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the window by one sample and work out the beat it produces.
    // Once full: oldest cell drops out of the sum, oldest guard cell joins it.
    function automatic t_detection predict_detection(logic signed [SAMPLE_W-1:0] s);
        t_detection d;
        longint     prod;
        longint     q;
        d = '0;
        if (cells_held == WIN_LEN) begin
            ref_sum = ref_sum - cell_ring[ring_slot]
                    + cell_ring[(ring_slot + C_REF_CELLS) % WIN_LEN];
        end else begin
            if (cells_held < C_REF_CELLS)
                ref_sum += s;
            cells_held++;
        end
        cell_ring[ring_slot] = s;
        ring_slot = (ring_slot + 1) % WIN_LEN;
        if (cells_held == WIN_LEN) begin
            prod = ref_sum * longint'(alpha_q8);
            // floor, not truncation toward zero
            q = prod / MEAN_DEN;
            if (prod < 0 && prod % MEAN_DEN != 0)
                q--;
            d.threshold = THR_W'(q);
            d.detect    = (longint'(s) * MEAN_DEN) > prod;
            d.valid_res = 1'b1;
        end
        return d;
    endfunction

    // Queue about count samples built from random segment shapes.
    task automatic queue_random_samples(int count);
        int       left;
        int       len;
        int       amp;
        int       bias;
        int       v;
        t_segment kind;
        left = count;
        while (left > 0) begin
            kind = t_segment'($urandom_range(2));
            case (kind)
                SEG_NOISE: begin
                    len = $urandom_range(40, 10);
                    repeat (len) pending_samples.push_back(16'($urandom));
                end
                SEG_CLUTTER: begin
                    len  = $urandom_range(80, 20);
                    amp  = $urandom_range(1000);
                    bias = int'($urandom_range(6000)) - 3000;
                    repeat (len) begin
                        if ($urandom_range(9) == 0) begin
                            v = $urandom_range(32767);
                            if ($urandom_range(1) == 0)
                                v = -v;
                        end else
                            v = bias + int'($urandom_range(2 * amp)) - amp;
                        pending_samples.push_back(16'(v));
                    end
                end
                default: begin
                    // flat window, then an equal and a one-above (one-below at 32767) cell under test
                    case ($urandom_range(2))
                        0:       v = 32767;
                        1:       v = -32768;
                        default: v = int'($signed(16'($urandom)));
                    endcase
                    len = WIN_LEN + 2;
                    repeat (WIN_LEN + 1) pending_samples.push_back(16'(v));
                    pending_samples.push_back(16'((v == 32767) ? v - 1 : v + 1));
                end
            endcase
            left -= len;
        end
    endtask

    // Block until every request has been taken and every result seen,
    // then let the pipeline settle.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_detections.size() != 0);
        repeat (PIPE_LATENCY + 3) @(negedge i_clk);
    endtask

    // Request driver: holds tdata until taken, random gaps per send_idle_pct.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_detections.push_back(predict_detection($signed(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_samples.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_detection want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_detections.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_detections.pop_front();
                    if (m_axis_tdata[THR_W-1:0] !== want.threshold) begin
                        $display("%0t: threshold mismatch: expected %0d, actual %0d", $time,
                                 want.threshold, $signed(m_axis_tdata[THR_W-1:0]));
                        mismatch_count++;
                    end
                    if (m_axis_tdata[THR_W] !== want.detect) begin
                        $display("%0t: detect mismatch: expected %b, actual %b",
                                 $time, want.detect, m_axis_tdata[THR_W]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:THR_W+1] !== '0) begin
                        $display("%0t: tdata pad mismatch: expected 0, actual %h",
                                 $time, m_axis_tdata[OUT_TDATA_W-1:THR_W+1]);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.valid_res) begin
                        $display("%0t: valid_res mismatch: expected %b, actual %b",
                                 $time, want.valid_res, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any handshake or config write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("cfar_threshold_detector_test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus: directed extremes while the window fills (reset alpha), then
    // phases of random runs, each under a new alpha written while idle.
    initial begin : stimulus
        logic [IN_TDATA_W-1:0] directed [14];
        int alpha_plan [PHASES-1];
        directed = '{
            16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
            16'h00FF, 16'hFF00, 16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0, 16'h4000
        };
        alpha_plan = '{0, 65535, 256, 1, 0, int'(ALPHA_RESET)};
        alpha_plan[4] = $urandom_range(65535);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                // sender holds off here until every result is back
                wait_until_drained();
                @(posedge i_clk);
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= ALPHA_W'(alpha_plan[p-1]);
                @(posedge i_clk);
                i_cfg_we    <= 1'b0;
                alpha_q8     = ALPHA_W'(alpha_plan[p-1]);
            end
            // sender-light/receiver-heavy, then swapped, then full rate
            if (p <= 2) begin
                send_idle_pct = 17;
                recv_idle_pct = 49;
            end else if (p <= 4) begin
                send_idle_pct = 49;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 0)
                foreach (directed[i]) pending_samples.push_back(directed[i]);
            queue_random_samples(PHASE_ITEMS);
        end

        wait_until_drained();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && expected_detections.size() == 0)
            $display("cfar_threshold_detector_test passed");
        else
            $display("cfar_threshold_detector_test failed");
        $finish;
    end

endmodule
